/* hdl/lzmt_pkg.sv */
// ----------------------------------------------------------------------------
// lzmt_pkg
// Shared types and constants of the match table decoder.
// ----------------------------------------------------------------------------
package lzmt_pkg;

  localparam int WIN_AW = 16;
  localparam int TAB_AW = 14;
  localparam int TAB_DW = 24;
  localparam logic [16:0] WINDOW_BYTES = 17'd65536;
  localparam logic [14:0] TABLE_ENTRIES = 15'd16384;
  localparam int BLOCK_SIZE_W = 24;

  typedef enum logic [3:0] {
    PH_FLAG, PH_LIT, PH_LEN4, PH_LEN2, PH_LEN7, PH_KIND, PH_POS, PH_IDX, PH_HALT
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE, S_TREAD, S_SETUP, S_RD, S_WR, S_EMIT
  } state_t;

endpackage

/* hdl/lzmt_in_if.sv */
// ----------------------------------------------------------------------------
// lzmt_in_if
// Input channel: block start or one code bit per transfer.
// ----------------------------------------------------------------------------
interface lzmt_in_if
  import lzmt_pkg::*;
  ();
  logic                    valid;
  logic                    ready;
  logic                    op;
  logic [BLOCK_SIZE_W-1:0] block_size;
  logic                    code_bit;

  modport source (output valid, output op, output block_size, output code_bit, input ready);
  modport sink (input valid, input op, input block_size, input code_bit, output ready);
endinterface

/* hdl/lzmt_out_if.sv */
// ----------------------------------------------------------------------------
// lzmt_out_if
// Output channel: up to eight decoded bytes per transfer with status.
// ----------------------------------------------------------------------------
interface lzmt_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_bytes;
  logic [3:0]  byte_count;
  logic        last_of_run;
  logic        block_done;
  logic        error;

  modport source (output valid, output data_bytes, output byte_count, output last_of_run,
                  output block_done, output error, input ready);
  modport sink (input valid, input data_bytes, input byte_count, input last_of_run,
                input block_done, input error, output ready);
endinterface

/* hdl/lz_match_table_decoder.sv */
// ----------------------------------------------------------------------------
// lz_match_table_decoder
// LZ77 style block decoder with a match table, fed one code bit per transfer.
// ----------------------------------------------------------------------------
// A block start or a code bit that does not finish a token takes one cycle. A
// literal finishes in that cycle with one result. A match takes one setup
// cycle (two with a table index, for the table read) and then two cycles per
// copied byte, since each byte is read from the history RAM and written back
// before the next may be read; each group of eight bytes is held until its
// result transfer completes. No new input is taken while a result waits.
module lz_match_table_decoder
  import lzmt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  lzmt_in_if.sink     in_ch,
  lzmt_out_if.source  out_ch
);
  state_t state, state_next;
  phase_t phase;
  logic [16:0] wi, target, acc;
  logic [4:0]  pw, iw, bits_left;
  logic [14:0] ec;
  logic [7:0]  tl, remain;
  logic [15:0] src, dst;
  logic [63:0] pack;
  logic [3:0]  pcnt;
  logic        done_flag;
  logic        out_valid;
  logic [63:0] o_data;
  logic [3:0]  o_cnt;
  logic        o_last, o_done, o_err;

  logic        in_xfer, out_xfer, bit_in, field_done, active;
  logic [16:0] acc_next, room;
  logic [4:0]  bl_dec;
  logic [17:0] pmask, lit_sum, mat_sum;
  logic [15:0] imask;
  logic [14:0] ec_inc;
  logic [7:0]  hrd, n_copy;
  logic [TAB_DW-1:0] trd;
  logic        h_we, t_we, pos_app;
  logic [WIN_AW-1:0] h_waddr;
  logic [7:0]  h_wdata;
  logic [TAB_AW-1:0] t_waddr;
  logic [TAB_DW-1:0] t_wdata;
  logic [63:0] pack_next;

  assign in_ch.ready = (state == S_IDLE) && !out_valid;
  assign in_xfer = in_ch.valid && in_ch.ready;
  assign out_xfer = out_valid && out_ch.ready;
  assign bit_in = in_ch.code_bit;
  assign acc_next = {acc[15:0], bit_in};
  assign bl_dec = bits_left - 5'd1;
  assign field_done = (bl_dec == 5'd0);
  assign active = in_xfer && in_ch.op && (phase != PH_HALT) && (wi < target);
  assign pmask = (18'd1 << pw) - 18'd1;
  assign lit_sum = {1'b0, wi} + 18'd1;
  assign mat_sum = {1'b0, wi} + {10'd0, tl};
  assign imask = (16'd1 << iw) - 16'd1;
  assign ec_inc = ec + 15'd1;
  assign room = target - wi;
  assign n_copy = (room < {9'd0, tl}) ? room[7:0] : tl;
  assign pos_app = active && (phase == PH_POS) && field_done && (acc_next < wi)
                   && (ec < TABLE_ENTRIES);
  assign pack_next = pack | ({56'd0, hrd} << {pcnt[2:0], 3'b000});

  assign h_we = (state == S_WR) || (active && (phase == PH_LIT) && field_done);
  assign h_waddr = (state == S_WR) ? dst : wi[WIN_AW-1:0];
  assign h_wdata = (state == S_WR) ? hrd : acc_next[7:0];
  assign t_we = pos_app || ((state == S_TREAD) && (tl > trd[23:16]));
  assign t_waddr = (state == S_TREAD) ? acc[TAB_AW-1:0] : ec[TAB_AW-1:0];
  assign t_wdata = (state == S_TREAD) ? {tl, trd[15:0]} : {tl, acc_next[15:0]};

  lzmt_ram #(.AW(WIN_AW), .DW(8)) u_hist (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata), .raddr(src), .rdata(hrd)
  );

  lzmt_ram #(.AW(TAB_AW), .DW(TAB_DW)) u_table (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(acc_next[TAB_AW-1:0]), .rdata(trd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (active && field_done && (phase == PH_POS) && (acc_next < wi)) begin
          state_next = S_SETUP;
        end else if (active && field_done && (phase == PH_IDX) && (acc_next < {2'b0, ec})) begin
          state_next = S_TREAD;
        end
      end
      S_TREAD: state_next = S_SETUP;
      S_SETUP: state_next = S_RD;
      S_RD:    state_next = S_WR;
      S_WR: begin
        if (remain == 8'd1) begin
          state_next = S_IDLE;
        end else if (pcnt == 4'd7) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_RD;
        end
      end
      S_EMIT: begin
        if (out_xfer) begin
          state_next = S_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_FLAG;
      wi <= '0;
      target <= '0;
      pw <= 5'd1;
      iw <= 5'd1;
      ec <= '0;
      acc <= '0;
      bits_left <= '0;
      tl <= 8'd1;
      out_valid <= 1'b0;
    end else begin
      if (out_xfer) begin
        out_valid <= 1'b0;
      end
      if (in_xfer && !in_ch.op) begin
        wi <= '0;
        target <= (in_ch.block_size > {7'd0, WINDOW_BYTES}) ? 17'd0 : in_ch.block_size[16:0];
        pw <= 5'd1;
        iw <= 5'd1;
        ec <= '0;
        phase <= PH_FLAG;
        acc <= '0;
        bits_left <= '0;
        tl <= 8'd1;
        out_valid <= 1'b1;
        o_data <= '0;
        o_cnt <= '0;
        o_last <= 1'b1;
        o_err <= in_ch.block_size > {7'd0, WINDOW_BYTES};
        o_done <= in_ch.block_size == '0;
      end else if (active) begin
        priority case (phase)
          PH_FLAG: begin
            if (bit_in) begin
              phase <= PH_LEN4;
            end else begin
              phase <= PH_LIT;
              acc <= '0;
              bits_left <= 5'd8;
            end
          end
          PH_LEN4: begin
            if (bit_in) begin
              tl <= 8'd4;
              phase <= PH_KIND;
            end else begin
              phase <= PH_LEN2;
              acc <= '0;
              bits_left <= 5'd2;
            end
          end
          PH_KIND: begin
            acc <= '0;
            if (bit_in) begin
              phase <= PH_POS;
              bits_left <= pw;
            end else begin
              phase <= PH_IDX;
              bits_left <= iw;
            end
          end
          PH_LIT, PH_LEN2, PH_LEN7, PH_POS, PH_IDX: begin
            acc <= acc_next;
            bits_left <= bl_dec;
            if (field_done) begin
              priority case (phase)
                PH_LIT: begin
                  if ((wi != '0) && (lit_sum > pmask) && (pw != 5'd31)) begin
                    pw <= pw + 5'd1;
                  end
                  wi <= lit_sum[16:0];
                  phase <= PH_FLAG;
                  tl <= 8'd1;
                  out_valid <= 1'b1;
                  o_data <= {56'd0, acc_next[7:0]};
                  o_cnt <= 4'd1;
                  o_last <= 1'b1;
                  o_done <= lit_sum[16:0] >= target;
                  o_err <= 1'b0;
                end
                PH_LEN2: begin
                  if (acc_next[1:0] == 2'b11) begin
                    phase <= PH_LEN7;
                    acc <= '0;
                    bits_left <= 5'd7;
                  end else begin
                    tl <= {6'd0, acc_next[1:0]} + 8'd5;
                    phase <= PH_KIND;
                  end
                end
                PH_LEN7: begin
                  tl <= {1'b0, acc_next[6:0]} + 8'd8;
                  phase <= PH_KIND;
                end
                default: begin
                  if (((phase == PH_POS) && (acc_next >= wi)) ||
                      ((phase == PH_IDX) && (acc_next >= {2'b0, ec}))) begin
                    phase <= PH_HALT;
                    out_valid <= 1'b1;
                    o_data <= '0;
                    o_cnt <= '0;
                    o_last <= 1'b1;
                    o_done <= 1'b0;
                    o_err <= 1'b1;
                  end else begin
                    phase <= PH_FLAG;
                    src <= acc_next[15:0];
                    if (pos_app) begin
                      ec <= ec_inc;
                      if ((({1'b0, ec_inc} & imask) == '0) && (iw != 5'd31)) begin
                        iw <= iw + 5'd1;
                      end
                    end
                  end
                end
              endcase
            end
          end
          default: phase <= PH_HALT;
        endcase
      end

      unique case (state)
        S_TREAD: src <= trd[15:0];
        S_SETUP: begin
          remain <= n_copy;
          done_flag <= room <= {9'd0, tl};
          dst <= wi[15:0];
          wi <= wi + {9'd0, n_copy};
          if ((wi != '0) && (mat_sum > pmask) && (pw != 5'd31)) begin
            pw <= pw + 5'd1;
          end
          tl <= 8'd1;
          pack <= '0;
          pcnt <= '0;
        end
        S_WR: begin
          src <= src + 16'd1;
          dst <= dst + 16'd1;
          remain <= remain - 8'd1;
          if ((remain == 8'd1) || (pcnt == 4'd7)) begin
            out_valid <= 1'b1;
            o_data <= pack_next;
            o_cnt <= pcnt + 4'd1;
            o_last <= remain == 8'd1;
            o_done <= done_flag;
            o_err <= 1'b0;
            pack <= '0;
            pcnt <= '0;
          end else begin
            pack <= pack_next;
            pcnt <= pcnt + 4'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.data_bytes = o_data;
  assign out_ch.byte_count = o_cnt;
  assign out_ch.last_of_run = o_last;
  assign out_ch.block_done = o_done;
  assign out_ch.error = o_err;

  a_emit_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> out_valid) else $error("emit state without a pending result");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (o_cnt <= 4'd8)) else $error("byte count above eight");
  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && o_err) |-> ((o_cnt == 4'd0) && !o_done && o_last))
    else $error("error result carries bytes or done");
  a_copy_left: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD) |-> (remain != 8'd0)) else $error("copy read with nothing left");
endmodule

/* hdl/lzmt_ram.sv */
// ----------------------------------------------------------------------------
// lzmt_ram
// Simple dual port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module lzmt_ram #(
  parameter int AW = 8,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [(1 << AW)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
